[sv/lcas_pkg.sv]
package lcas_pkg;

    localparam int LCAS_MAX_COLS = 64;
    localparam int LCAS_MAX_ROWS = 64;

    localparam int CFG_W = 7;

    // register indexes on the config port
    localparam logic CFG_GRID_WIDTH  = 1'b0;
    localparam logic CFG_GRID_HEIGHT = 1'b1;

    // opcodes
    localparam logic [1:0] OP_WRITE   = 2'd0;
    localparam logic [1:0] OP_READ    = 2'd1;
    localparam logic [1:0] OP_ADVANCE = 2'd2;

    // neighbor counts of the rule
    localparam logic [3:0] BIRTH_COUNT = 4'd3;
    localparam logic [3:0] KEEP_COUNT  = 4'd2;

endpackage

[sv/lcas_row_rule.sv]
module lcas_row_rule
    import lcas_pkg::*;
#(
    parameter int MAX_COLS = LCAS_MAX_COLS
)
(
    input  logic [MAX_COLS-1:0]               top,
    input  logic [MAX_COLS-1:0]               mid,
    input  logic [MAX_COLS-1:0]               bot,
    input  logic [$clog2(MAX_COLS+1)-1:0]     width,
    output logic [MAX_COLS-1:0]               next_row,
    output logic                              changed
);

    localparam int COL_CNT_W = $clog2(MAX_COLS + 1);
    localparam int COL_AW    = $clog2(MAX_COLS);

    logic [COL_AW-1:0] last_idx;
    logic              top_last;
    logic              mid_last;
    logic              bot_last;

    assign last_idx = COL_AW'(width - COL_CNT_W'(1));
    assign top_last = top[last_idx];
    assign mid_last = mid[last_idx];
    assign bot_last = bot[last_idx];

    for (genvar c = 0; c < MAX_COLS; c++)
    begin : g_col
        localparam int LI = (c == 0) ? 0 : c - 1;
        localparam int RI = (c == MAX_COLS - 1) ? 0 : c + 1;

        logic       at_last;
        logic       used;
        logic       tl, tr, ml, mr, bl, br;
        logic [3:0] cnt;
        logic       live;

        assign at_last = (COL_CNT_W'(c) == width - COL_CNT_W'(1));
        assign used    = (COL_CNT_W'(c) < width);

        // column wrap: left of column 0 is the last used column, right of it is column 0
        assign tl = (c == 0) ? top_last : top[LI];
        assign ml = (c == 0) ? mid_last : mid[LI];
        assign bl = (c == 0) ? bot_last : bot[LI];
        assign tr = at_last ? top[0] : top[RI];
        assign mr = at_last ? mid[0] : mid[RI];
        assign br = at_last ? bot[0] : bot[RI];

        assign cnt = 4'(tl) + 4'(top[c]) + 4'(tr) + 4'(ml) + 4'(mr)
                   + 4'(bl) + 4'(bot[c]) + 4'(br);
        assign live = (cnt == BIRTH_COUNT) || ((cnt == KEEP_COUNT) && mid[c]);
        assign next_row[c] = used ? live : mid[c];
    end

    assign changed = |(next_row ^ mid);

endmodule

[sv/life_cellular_automaton_step.sv]
// Toroidal Game of Life engine. The grid lives in one synchronous memory of
// 2 x 2**ROW_AW row words (two banks, MAX_COLS cells per word); an advance reads
// the current bank one row per cycle through a three-row window and writes the
// new generation to the other bank, then swaps banks. A cell write or read first
// reads its row; a write then modifies and writes it back before its result is
// raised, while an item that touches no cell goes straight to the done state. An
// advance drives the single read port with one row per cycle: every row is read
// once, rows height-1 and 0 are read a second time for the row wrap, and the
// window and write-back stages drain after the last read, before the result is
// raised. One item is in work at a time; the result sits in an output register,
// and the next item is taken from the cycle the result is raised, while it waits.
// After reset every row reads as dead through per-row valid bits, so there is no
// clearing pass.
module life_cellular_automaton_step
    import lcas_pkg::*;
#(
    parameter int MAX_COLS = LCAS_MAX_COLS,
    parameter int MAX_ROWS = LCAS_MAX_ROWS
)
(
    input  logic             clk,
    input  logic             rst_n,

    input  logic             cfg_wr_en,
    input  logic             cfg_index,
    input  logic [CFG_W-1:0] cfg_data,

    input  logic             in_valid,
    output logic             in_ready,
    input  logic [1:0]       opcode,
    input  logic [5:0]       row,
    input  logic [5:0]       col,
    input  logic             cell_in,

    output logic             out_valid,
    input  logic             out_ready,
    output logic             cell_out,
    output logic             grid_changed
);

    localparam int COL_CNT_W = $clog2(MAX_COLS + 1);
    localparam int COL_AW    = $clog2(MAX_COLS);
    localparam int ROW_CNT_W = $clog2(MAX_ROWS + 1);
    localparam int ROW_AW    = $clog2(MAX_ROWS);
    localparam int MEM_AW    = ROW_AW + 1;
    localparam int MEM_DEPTH = 2 ** MEM_AW;
    localparam int ISS_W     = $clog2(MAX_ROWS + 3);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_CELL = 4'b0010,
        S_ADV  = 4'b0100,
        S_DONE = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    logic [CFG_W-1:0] grid_width_reg;
    logic [CFG_W-1:0] grid_height_reg;
    logic [COL_CNT_W-1:0] w_eff;
    logic [ROW_CNT_W-1:0] h_eff;

    logic [1:0]        op_reg;
    logic [ROW_AW-1:0] row_idx_reg;
    logic [COL_AW-1:0] col_idx_reg;
    logic              val_reg;
    logic              bank_reg;

    logic              res_cell_reg;
    logic              chg_reg;
    logic              out_valid_reg;
    logic              cell_out_reg;
    logic              grid_changed_reg;

    // grid memory and per-row valid bits
    logic [MAX_COLS-1:0]  grid_mem [MEM_DEPTH];
    logic [MEM_DEPTH-1:0] row_valid_reg;
    logic [MAX_COLS-1:0]  rd_data_reg;
    logic                 rd_valid_reg;
    logic [MAX_COLS-1:0]  rd_word;

    logic                 mem_re;
    logic [MEM_AW-1:0]    mem_ra;
    logic                 mem_we;
    logic [MEM_AW-1:0]    mem_wa;
    logic [MAX_COLS-1:0]  mem_wd;

    // advance sweep
    logic [ISS_W-1:0]    iss_cnt_reg;
    logic [ROW_AW-1:0]   seq_row_reg;
    logic                issuing;
    logic                win_read;
    logic [ROW_AW-1:0]   sweep_row;
    logic                b_v_reg;
    logic                b_wr_reg;
    logic                b_copy_reg;
    logic [ROW_AW-1:0]   b_row_reg;
    logic                c_wr_reg;
    logic                c_copy_reg;
    logic [ROW_AW-1:0]   c_row_reg;
    logic [MAX_COLS-1:0] top_reg;
    logic [MAX_COLS-1:0] mid_reg;
    logic [MAX_COLS-1:0] bot_reg;
    logic [MAX_COLS-1:0] rule_row;
    logic                rule_chg;

    logic                accept;
    logic                in_area;
    logic [MAX_COLS-1:0] merged_word;

    // effective sizes, clamped to 1..MAX
    always_comb
    begin
        if (grid_width_reg == '0)
            w_eff = COL_CNT_W'(1);
        else if (int'(grid_width_reg) > MAX_COLS)
            w_eff = COL_CNT_W'(MAX_COLS);
        else
            w_eff = COL_CNT_W'(grid_width_reg);

        if (grid_height_reg == '0)
            h_eff = ROW_CNT_W'(1);
        else if (int'(grid_height_reg) > MAX_ROWS)
            h_eff = ROW_CNT_W'(MAX_ROWS);
        else
            h_eff = ROW_CNT_W'(grid_height_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_width_reg  <= CFG_W'(64);
            grid_height_reg <= CFG_W'(64);
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                CFG_GRID_WIDTH:  grid_width_reg  <= cfg_data;
                CFG_GRID_HEIGHT: grid_height_reg <= cfg_data;
            endcase
        end
    end

    assign in_ready = (state_reg == S_IDLE);
    assign accept   = in_valid && in_ready;
    assign in_area  = (int'(row) < int'(h_eff)) && (int'(col) < int'(w_eff));

    // sweep: h+2 window reads (h-1, 0, 1 .. h-1, 0), then copies of unused rows
    assign issuing   = (state_reg == S_ADV) && (iss_cnt_reg < ISS_W'(MAX_ROWS + 2));
    assign win_read  = (iss_cnt_reg < ISS_W'(h_eff) + ISS_W'(2));
    assign sweep_row = ROW_AW'(iss_cnt_reg - ISS_W'(2));

    always_comb
    begin
        mem_re = 1'b0;
        mem_ra = {bank_reg, ROW_AW'(row)};
        if (accept && in_area && (opcode == OP_WRITE || opcode == OP_READ))
            mem_re = 1'b1;
        else if (issuing)
        begin
            mem_re = 1'b1;
            mem_ra = {bank_reg, win_read ? seq_row_reg : sweep_row};
        end
    end

    always_comb
    begin
        merged_word = rd_word;
        merged_word[col_idx_reg] = val_reg;
    end

    always_comb
    begin
        mem_we = 1'b0;
        mem_wa = {bank_reg, row_idx_reg};
        mem_wd = merged_word;
        if (state_reg == S_CELL && op_reg == OP_WRITE)
            mem_we = 1'b1;
        else if (state_reg == S_ADV && c_wr_reg)
        begin
            mem_we = 1'b1;
            mem_wa = {~bank_reg, c_row_reg};
            mem_wd = c_copy_reg ? bot_reg : rule_row;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            grid_mem[mem_wa] <= mem_wd;
        if (mem_re)
            rd_data_reg <= grid_mem[mem_ra];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_valid_reg <= '0;
            rd_valid_reg  <= 1'b0;
        end
        else
        begin
            if (mem_we)
                row_valid_reg[mem_wa] <= 1'b1;
            if (mem_re)
                rd_valid_reg <= row_valid_reg[mem_ra];
        end
    end

    assign rd_word = rd_valid_reg ? rd_data_reg : '0;

    lcas_row_rule #(
        .MAX_COLS (MAX_COLS)
    ) u_rule (
        .top      (top_reg),
        .mid      (mid_reg),
        .bot      (bot_reg),
        .width    (w_eff),
        .next_row (rule_row),
        .changed  (rule_chg)
    );

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (opcode == OP_ADVANCE)
                        state_next = S_ADV;
                    else if (in_area && (opcode == OP_WRITE || opcode == OP_READ))
                        state_next = S_CELL;
                    else
                        state_next = S_DONE;
                end
            end
            S_CELL:
                state_next = S_DONE;
            S_ADV:
            begin
                if (!issuing && !b_v_reg && !c_wr_reg)
                    state_next = S_DONE;
            end
            S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                    state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            bank_reg      <= 1'b0;
            iss_cnt_reg   <= '0;
            b_v_reg       <= 1'b0;
            c_wr_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            if (accept)
                iss_cnt_reg <= '0;
            else if (issuing)
                iss_cnt_reg <= iss_cnt_reg + ISS_W'(1);

            b_v_reg  <= issuing;
            c_wr_reg <= b_v_reg && b_wr_reg;

            if (state_reg == S_ADV && state_next == S_DONE)
                bank_reg <= ~bank_reg;

            if (state_reg == S_DONE && state_next == S_IDLE)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg       <= opcode;
            row_idx_reg  <= ROW_AW'(row);
            col_idx_reg  <= COL_AW'(col);
            val_reg      <= cell_in;
            res_cell_reg <= 1'b0;
            chg_reg      <= 1'b0;
            seq_row_reg  <= ROW_AW'(h_eff - ROW_CNT_W'(1));
        end
        else
        begin
            if (state_reg == S_CELL && op_reg == OP_READ)
                res_cell_reg <= rd_word[col_idx_reg];
            if (issuing && win_read)
            begin
                if (ROW_CNT_W'(seq_row_reg) == h_eff - ROW_CNT_W'(1))
                    seq_row_reg <= '0;
                else
                    seq_row_reg <= seq_row_reg + ROW_AW'(1);
            end
            if (state_reg == S_ADV && c_wr_reg && !c_copy_reg && rule_chg)
                chg_reg <= 1'b1;
        end

        b_wr_reg   <= (iss_cnt_reg >= ISS_W'(2));
        b_copy_reg <= !win_read;
        b_row_reg  <= sweep_row;

        if (b_v_reg)
        begin
            top_reg <= mid_reg;
            mid_reg <= bot_reg;
            bot_reg <= rd_word;
        end
        c_copy_reg <= b_copy_reg;
        c_row_reg  <= b_row_reg;

        if (state_reg == S_DONE && state_next == S_IDLE)
        begin
            cell_out_reg     <= res_cell_reg;
            grid_changed_reg <= chg_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign cell_out     = cell_out_reg;
    assign grid_changed = grid_changed_reg;

`ifndef SYNTHESIS
    a_no_same_entry: assert property (@(posedge clk) disable iff (!rst_n)
        (mem_we && mem_re) |-> (mem_wa != mem_ra))
        else $error("read and write of the same grid row in one cycle");

    a_adv_other_bank: assert property (@(posedge clk) disable iff (!rst_n)
        (mem_we && state_reg == S_ADV) |-> (mem_wa[MEM_AW-1] != bank_reg))
        else $error("advance wrote into the bank it reads");

    a_adv_start: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && opcode == OP_ADVANCE) |=> (state_reg == S_ADV && iss_cnt_reg == '0))
        else $error("advance did not start a fresh sweep");

    a_pipe_in_adv: assert property (@(posedge clk) disable iff (!rst_n)
        (b_v_reg || c_wr_reg) |-> (state_reg == S_ADV))
        else $error("sweep pipeline busy outside an advance");

    a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_DONE))
        else $error("result beat raised outside the done state");
`endif

endmodule
